// File: src/qcf_pkg.sv
// ----------------------------------------------------------------------------
// qcf_pkg: shared types and constants of the quadratic curve flattener
// Coordinate width, depth limit, sequencer states and the halving helper.
// ----------------------------------------------------------------------------
package qcf_pkg;

    localparam int COORD_BITS  = 12;
    localparam int MAX_DEPTH   = 6;
    localparam int THR_BITS    = 8;
    localparam int DEV_BITS    = COORD_BITS + 1;
    localparam int LVL_BITS    = $clog2(MAX_DEPTH + 1);
    localparam int IDX_BITS    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(5);

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [LVL_BITS-1:0]   t_level;

    // three control points along one axis
    typedef struct packed {
        t_coord p0;
        t_coord p1;
        t_coord p2;
    } t_axis_pts;

    // result of one midpoint split along one axis
    typedef struct packed {
        t_coord left_ctl;
        t_coord mid;
        t_coord right_ctl;
        t_coord dev;
    } t_axis_split;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_EVAL,
        ST_EMIT
    } t_state;

    // truncating midpoint of two coordinates
    function automatic t_coord f_half(input t_coord a, input t_coord b);
        logic [COORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COORD_BITS:1];
    endfunction

endpackage

// File: src/qcf_axis_unit.sv
// ----------------------------------------------------------------------------
// qcf_axis_unit: midpoint split and deviation along one axis
// Computes the de Casteljau halves and the distance of the control point
// from the chord midpoint for one coordinate axis.
// ----------------------------------------------------------------------------
module qcf_axis_unit
    import qcf_pkg::*;
(
    input  t_axis_pts   i_pts,
    output t_axis_split o_split
);

    t_coord w_left;
    t_coord w_right;
    t_coord w_chord;

    // split the curve at its middle
    assign w_left  = f_half(i_pts.p0, i_pts.p1);
    assign w_right = f_half(i_pts.p1, i_pts.p2);
    assign w_chord = f_half(i_pts.p0, i_pts.p2);

    always_comb begin
        o_split.left_ctl  = w_left;
        o_split.right_ctl = w_right;
        o_split.mid       = f_half(w_left, w_right);
        // absolute distance of control point from chord midpoint
        if (i_pts.p1 >= w_chord) begin
            o_split.dev = i_pts.p1 - w_chord;
        end else begin
            o_split.dev = w_chord - i_pts.p1;
        end
    end

endmodule

// File: src/quadratic_curve_flattener_top.sv
// After a curve is taken, the first segment is valid once the splits on the
// leftmost path, the unconditional first split included, are done.
// A curve holds the block until its last segment is taken: each segment takes a
// split or accept step, an evaluation and an output step, as the split/deviation
// units (one per axis) and the one-deep output register serve one curve at a time.
// Reset (synchronous, active low) empties the stack, drops any output and
// restores the flatness threshold to 5.
// ----------------------------------------------------------------------------
// quadratic_curve_flattener_top: adaptive quadratic curve subdivision
// Splits one curve depth-first with a stack of deferred right halves and
// emits each half that is flat enough or at the depth limit as one line segment.
// ----------------------------------------------------------------------------
module quadratic_curve_flattener_top
    import qcf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [THR_BITS-1:0] i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_coord              i_start_x,
    input  t_coord              i_start_y,
    input  t_coord              i_control_x,
    input  t_coord              i_control_y,
    input  t_coord              i_end_x,
    input  t_coord              i_end_y,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_coord              o_seg_from_x,
    output t_coord              o_seg_from_y,
    output t_coord              o_seg_to_x,
    output t_coord              o_seg_to_y,
    output logic                o_final_segment
);

    t_state r_state;
    t_state n_state;

    logic [THR_BITS-1:0] r_thr;
    t_axis_pts           r_work_x;
    t_axis_pts           r_work_y;
    t_level              r_level;
    t_level              r_top;

    // deferred right halves
    t_axis_pts           r_stk_x   [MAX_DEPTH];
    t_axis_pts           r_stk_y   [MAX_DEPTH];
    t_level              r_stk_lvl [MAX_DEPTH];

    t_coord              r_from_x;
    t_coord              r_from_y;
    t_coord              r_to_x;
    t_coord              r_to_y;
    logic                r_final;

    t_axis_split         w_sx;
    t_axis_split         w_sy;
    logic [DEV_BITS-1:0] w_dev;
    logic                w_can_split;
    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_stk_empty;
    logic                w_do_split;
    logic                w_do_emit;
    logic                w_do_pop;
    t_level              w_push_lvl;
    logic [IDX_BITS-1:0] w_wr_idx;
    logic [IDX_BITS-1:0] w_rd_idx;

    // split and deviation units, one per axis
    qcf_axis_unit u_axis_x (
        .i_pts   (r_work_x),
        .o_split (w_sx)
    );

    qcf_axis_unit u_axis_y (
        .i_pts   (r_work_y),
        .o_split (w_sy)
    );

    assign w_dev       = {1'b0, w_sx.dev} + {1'b0, w_sy.dev};
    assign w_stk_empty = (r_top == '0);
    assign w_can_split = (r_level < LVL_BITS'(MAX_DEPTH))
                       && (w_dev > DEV_BITS'(r_thr))
                       && (r_top < LVL_BITS'(MAX_DEPTH));
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_wr_idx    = r_top[IDX_BITS-1:0];
    assign w_rd_idx    = IDX_BITS'(r_top - t_level'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!w_can_split) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    n_state = w_stk_empty ? ST_IDLE : ST_EVAL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        w_do_split  = 1'b0;
        w_do_emit   = 1'b0;
        w_do_pop    = 1'b0;
        w_push_lvl  = r_level;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_FIRST: begin
                w_do_split = 1'b1;
            end
            ST_EVAL: begin
                w_do_split = w_can_split;
                w_do_emit  = !w_can_split;
                w_push_lvl = r_level + t_level'(1);
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                w_do_pop    = i_out_ready && !w_stk_empty;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_thr   <= THR_RESET;
            r_top   <= '0;
            r_level <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (w_in_acc) begin
                r_top   <= '0;
                r_level <= t_level'(1);
            end else if (w_do_split) begin
                r_top   <= r_top + t_level'(1);
                r_level <= w_push_lvl;
            end else if (w_do_pop) begin
                r_top   <= r_top - t_level'(1);
                r_level <= r_stk_lvl[w_rd_idx];
            end
        end
    end

    // working curve: load, keep left half, or pop a deferred half
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_work_x <= '{p0: i_start_x, p1: i_control_x, p2: i_end_x};
            r_work_y <= '{p0: i_start_y, p1: i_control_y, p2: i_end_y};
        end else if (w_do_split) begin
            r_work_x.p1 <= w_sx.left_ctl;
            r_work_x.p2 <= w_sx.mid;
            r_work_y.p1 <= w_sy.left_ctl;
            r_work_y.p2 <= w_sy.mid;
        end else if (w_do_pop) begin
            r_work_x <= r_stk_x[w_rd_idx];
            r_work_y <= r_stk_y[w_rd_idx];
        end
    end

    // push the right half
    always_ff @(posedge i_clk) begin
        if (w_do_split) begin
            r_stk_x[w_wr_idx]   <= '{p0: w_sx.mid, p1: w_sx.right_ctl, p2: r_work_x.p2};
            r_stk_y[w_wr_idx]   <= '{p0: w_sy.mid, p1: w_sy.right_ctl, p2: r_work_y.p2};
            r_stk_lvl[w_wr_idx] <= w_push_lvl;
        end
    end

    // capture the segment
    always_ff @(posedge i_clk) begin
        if (w_do_emit) begin
            r_from_x <= r_work_x.p0;
            r_from_y <= r_work_y.p0;
            r_to_x   <= r_work_x.p2;
            r_to_y   <= r_work_y.p2;
            r_final  <= w_stk_empty;
        end
    end

    assign o_seg_from_x    = r_from_x;
    assign o_seg_from_y    = r_from_y;
    assign o_seg_to_x      = r_to_x;
    assign o_seg_to_y      = r_to_y;
    assign o_final_segment = r_final;

endmodule

// File: tb/tb_quadratic_curve_flattener_top.sv
// ----------------------------------------------------------------------------
// tb_quadratic_curve_flattener_top: self-checking bench for the curve flattener
// Feeds quadratic curves through a valid/ready port and predicts every line
// segment with a local depth-first subdivision model. It starts with a
// directed table, then runs phases of random curves at several flatness
// thresholds. Idle gaps and a long receiver hold are applied on both sides.
// ----------------------------------------------------------------------------
module tb_quadratic_curve_flattener_top;
    import qcf_pkg::*;

    localparam int KEEP          = -1;      // table row keeps the current threshold
    localparam int DIRECTED_ROWS = 18;
    localparam int PHASES        = 6;
    localparam int PHASE_CURVES  = 50;
    localparam int SEG_CAP       = 1 << MAX_DEPTH;
    localparam int SETTLE        = 4;       // idle cycles before a threshold write
    localparam int DRAIN         = 40;      // quiet cycles after the last segment
    localparam int HOLD_AT       = DIRECTED_ROWS + 20;
    localparam int HOLD_CYCLES   = 500;
    // worst case: every curve gives 64 segments, each waits out the longest receiver stall
    localparam int CYCLE_LIMIT   = 3_000_000;

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord cx;
        t_coord cy;
        t_coord ex;
        t_coord ey;
    } t_curve;

    typedef struct packed {
        int     thr;
        t_curve c;
        bit     pinned;     // expected segments typed in: a single repeated point
    } t_plan_row;

    typedef struct packed {
        t_coord from_x;
        t_coord from_y;
        t_coord to_x;
        t_coord to_y;
        logic   last;
    } t_seg;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [THR_BITS-1:0] i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_ready;
    t_coord              i_start_x;
    t_coord              i_start_y;
    t_coord              i_control_x;
    t_coord              i_control_y;
    t_coord              i_end_x;
    t_coord              i_end_y;
    logic                o_out_valid;
    logic                i_out_ready;
    t_coord              o_seg_from_x;
    t_coord              o_seg_from_y;
    t_coord              o_seg_to_x;
    t_coord              o_seg_to_y;
    logic                o_final_segment;

    logic [THR_BITS-1:0] thr_model;
    t_seg                segs_due[$];
    int                  fault_count  = 0;
    int                  curves_taken = 0;
    int                  cycle_count  = 0;
    int                  send_calm    = 0;
    int                  take_calm    = 0;
    bit                  hold_done    = 1'b0;
    t_plan_row           plan [DIRECTED_ROWS];

    quadratic_curve_flattener_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_control_x     (i_control_x),
        .i_control_y     (i_control_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_seg_from_x    (o_seg_from_x),
        .o_seg_from_y    (o_seg_from_y),
        .o_seg_to_x      (o_seg_to_x),
        .o_seg_to_y      (o_seg_to_y),
        .o_final_segment (o_final_segment)
    );

    always #5 i_clk = ~i_clk;

    // truncating midpoint
    function automatic t_coord halfway(input t_coord a, input t_coord b);
        return t_coord'((int'(a) + int'(b)) >> 1);
    endfunction

    function automatic int axis_dist(input t_coord a, input t_coord b);
        return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Manhattan distance from the control point to the chord midpoint
    function automatic int bend(input t_coord [2:0] wx, input t_coord [2:0] wy);
        return axis_dist(wx[1], halfway(wx[0], wx[2]))
             + axis_dist(wy[1], halfway(wy[0], wy[2]));
    endfunction

    // Subdivide one curve depth-first and queue the segments it yields
    function automatic void flatten_curve(input t_curve c, input logic [THR_BITS-1:0] thr);
        t_coord [2:0] wx;
        t_coord [2:0] wy;
        t_coord [2:0] stk_x [MAX_DEPTH];
        t_coord [2:0] stk_y [MAX_DEPTH];
        int           stk_lvl [MAX_DEPTH];
        int           top;
        int           level;
        int           n;
        bit           opening;
        t_coord       ax, ay, cx, cy, bx, by;
        t_seg         s;
        wx      = {c.ex, c.cx, c.sx};
        wy      = {c.ey, c.cy, c.sy};
        top     = 0;
        level   = 1;
        n       = 0;
        opening = 1'b1;
        while (n < SEG_CAP) begin
            // split: defer the right half, keep working on the left half
            if (opening || (level < MAX_DEPTH && bend(wx, wy) > int'(thr)
                            && top < MAX_DEPTH)) begin
                ax = halfway(wx[0], wx[1]);
                ay = halfway(wy[0], wy[1]);
                cx = halfway(wx[1], wx[2]);
                cy = halfway(wy[1], wy[2]);
                bx = halfway(ax, cx);
                by = halfway(ay, cy);
                stk_x[top]   = {wx[2], cx, bx};
                stk_y[top]   = {wy[2], cy, by};
                stk_lvl[top] = opening ? 1 : level + 1;
                top++;
                wx = {bx, ax, wx[0]};
                wy = {by, ay, wy[0]};
                if (!opening) level++;
                opening = 1'b0;
                continue;
            end
            // emit the chord, then resume the most recent deferred half
            s.from_x = wx[0];
            s.from_y = wy[0];
            s.to_x   = wx[2];
            s.to_y   = wy[2];
            s.last   = (top == 0);
            segs_due.push_back(s);
            n++;
            if (top == 0) break;
            top--;
            wx    = stk_x[top];
            wy    = stk_y[top];
            level = stk_lvl[top];
        end
    endfunction

    // Idle length: mostly none, some short, a few long, with calm stretches
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Random curve: mixes wide, tight, straight, corner and looped shapes
    function automatic t_curve fresh_curve();
        t_curve c;
        int     base_x, base_y;
        c = t_curve'({$urandom, $urandom, $urandom});
        case ($urandom_range(0, 9))
            5, 6: begin
                base_x = $urandom_range(0, 4095 - 63);
                base_y = $urandom_range(0, 4095 - 63);
                c.sx = t_coord'(base_x + $urandom_range(0, 63));
                c.sy = t_coord'(base_y + $urandom_range(0, 63));
                c.cx = t_coord'(base_x + $urandom_range(0, 63));
                c.cy = t_coord'(base_y + $urandom_range(0, 63));
                c.ex = t_coord'(base_x + $urandom_range(0, 63));
                c.ey = t_coord'(base_y + $urandom_range(0, 63));
            end
            7: begin
                c.cx = halfway(c.sx, c.ex) ^ t_coord'($urandom_range(0, 1));
                c.cy = halfway(c.sy, c.ey) ^ t_coord'($urandom_range(0, 1));
            end
            8: begin
                c.sx = $urandom_range(0, 1) ? '1 : '0;
                c.sy = $urandom_range(0, 1) ? '1 : '0;
                c.cx = $urandom_range(0, 1) ? '1 : '0;
                c.cy = $urandom_range(0, 1) ? '1 : '0;
                c.ex = $urandom_range(0, 1) ? '1 : '0;
                c.ey = $urandom_range(0, 1) ? '1 : '0;
            end
            9: begin
                c.ex = c.sx;
                c.ey = c.sy;
            end
            default: ;
        endcase
        return c;
    endfunction

    // Offer one curve, hold it until taken, then queue its segments
    task automatic send_curve(input t_curve c, input bit pinned);
        int   gap;
        t_seg s;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_start_x   <= c.sx;
        i_start_y   <= c.sy;
        i_control_x <= c.cx;
        i_control_y <= c.cy;
        i_end_x     <= c.ex;
        i_end_y     <= c.ey;
        do @(posedge i_clk); while (!o_in_ready);
        if (pinned) begin
            s = '{c.sx, c.sy, c.sx, c.sy, 1'b0};
            segs_due.push_back(s);
            s.last = 1'b1;
            segs_due.push_back(s);
        end else begin
            flatten_curve(c, thr_model);
        end
    endtask

    // Write the threshold once the block has drained
    task automatic set_threshold(input logic [THR_BITS-1:0] thr);
        i_in_valid <= 1'b0;
        while (segs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= thr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        thr_model = thr;
    endtask

    // Stimulus: reset, directed table, then random phases
    initial begin
        t_plan_row r;
        logic [THR_BITS-1:0] thr;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_out_ready   = 1'b0;
        i_start_x     = '0;
        i_start_y     = '0;
        i_control_x   = '0;
        i_control_y   = '0;
        i_end_x       = '0;
        i_end_y       = '0;
        thr_model     = THR_RESET;
        plan = '{
            '{KEEP, '{12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000}, 1'b1},
            '{KEEP, '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b1},
            '{KEEP, '{12'h5A5, 12'hA5A, 12'h5A5, 12'hA5A, 12'h5A5, 12'hA5A}, 1'b1},
            '{KEEP, '{12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h000}, 1'b0},
            '{KEEP, '{12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'hFFF, 12'hFFF}, 1'b0},
            '{KEEP, '{12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'hFFF, 12'hFFF}, 1'b0},
            '{KEEP, '{12'h000, 12'h000, 12'h7FF, 12'h7FF, 12'hFFF, 12'hFFF}, 1'b0},
            '{KEEP, '{12'hFFF, 12'h000, 12'h000, 12'hFFF, 12'h000, 12'h000}, 1'b0},
            '{0,    '{12'h064, 12'h064, 12'h068, 12'h060, 12'h06C, 12'h064}, 1'b0},
            '{0,    '{12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h000}, 1'b0},
            '{0,    '{12'h123, 12'hFED, 12'h123, 12'hFED, 12'h123, 12'hFED}, 1'b1},
            '{0,    '{12'hFFF, 12'h000, 12'h800, 12'h800, 12'h000, 12'hFFF}, 1'b0},
            '{255,  '{12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h000}, 1'b0},
            '{255,  '{12'h000, 12'h000, 12'h258, 12'h000, 12'h000, 12'h000}, 1'b0},
            '{255,  '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 1'b1},
            '{1,    '{12'h3E8, 12'h3E8, 12'h3EB, 12'h3E8, 12'h3E8, 12'h3E8}, 1'b0},
            '{6,    '{12'h00A, 12'h00A, 12'h016, 12'h00A, 12'h00A, 12'h00A}, 1'b0},
            '{5,    '{12'hFFF, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'h000}, 1'b0}
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table; the first rows run at the reset threshold
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            r = plan[i];
            if (r.thr != KEEP && r.thr != int'(thr_model))
                set_threshold(THR_BITS'(r.thr));
            send_curve(r.c, r.pinned);
        end

        // random curves, one threshold per phase
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       thr = '0;
                1:       thr = '1;
                2:       thr = THR_BITS'($urandom_range(1, 12));
                3:       thr = THR_BITS'(1);
                4:       thr = THR_BITS'($urandom_range(20, 254));
                default: thr = THR_BITS'($urandom);
            endcase
            set_threshold(thr);
            for (int i = 0; i < PHASE_CURVES; i++)
                send_curve(fresh_curve(), 1'b0);
        end

        // drain and report
        i_in_valid <= 1'b0;
        while (segs_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fault_count == 0 && segs_due.size() == 0) begin
            $display("tb_quadratic_curve_flattener_top: PASS");
        end else begin
            $display("tb_quadratic_curve_flattener_top: FAIL");
        end
        $finish;
    end

    // Segment receiver: random stalls plus one long hold to back up the input
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!hold_done && curves_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                gap = pick_gap(take_calm);
                if (gap == 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // Count curves taken by the block
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) curves_taken <= curves_taken + 1;
    end

    // Compare each segment transaction with the oldest expected segment
    always @(posedge i_clk) begin
        t_seg got;
        t_seg want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_seg_from_x, o_seg_from_y, o_seg_to_x, o_seg_to_y, o_final_segment};
            if (segs_due.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected segment (%0d,%0d)->(%0d,%0d) final %0b",
                             got.from_x, got.from_y, got.to_x, got.to_y, got.last);
                fault_count++;
            end else begin
                want = segs_due.pop_front();
                if (got.from_x !== want.from_x || got.from_y !== want.from_y ||
                    got.to_x !== want.to_x || got.to_y !== want.to_y ||
                    got.last !== want.last) begin
                    if (fault_count < 10)
                        $display("segment mismatch: expected (%0d,%0d)->(%0d,%0d) final %0b, %s",
                                 want.from_x, want.from_y, want.to_x, want.to_y, want.last,
                                 $sformatf("got (%0d,%0d)->(%0d,%0d) final %0b",
                                           got.from_x, got.from_y, got.to_x, got.to_y,
                                           got.last));
                    fault_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_quadratic_curve_flattener_top: FAIL");
            $finish;
        end
    end

endmodule
